// File: hdl/bct_pkg.sv
package bct_pkg;

  localparam int unsigned BLOCK_COUNT = 65536;
  localparam int unsigned DUP_ENTRIES = 128;

  // busy map is kept as rows of sixteen blocks
  localparam int unsigned MAP_ROWS  = (BLOCK_COUNT + 15) / 16;
  localparam int unsigned ROW_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int unsigned IDX_W     = $clog2(DUP_ENTRIES);
  localparam int unsigned DUP_W     = $clog2(DUP_ENTRIES + 1);
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    V_CONTINUE  = 3'd0,
    V_BAD       = 3'd1,
    V_DUP       = 3'd2,
    V_STOP_BAD  = 3'd3,
    V_STOP_DUP  = 3'd4,
    V_STOP_FULL = 3'd5
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_BLOCKS = 2'd0,
    REG_INODE_BLOCKS = 2'd1,
    REG_MAX_BAD      = 2'd2,
    REG_MAX_DUP      = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_TEST,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [ROW_W-1:0] row;
    logic [15:0]      wdata;
  } map_req_t;

  function automatic logic [3:0] sat_inc(input logic [3:0] c);
    return (c == 4'hf) ? 4'hf : c + 4'd1;
  endfunction

endpackage

// File: hdl/bct_if.sv
interface bct_claim_if;
  logic        valid;
  logic        ready;
  logic        new_inode;
  logic [15:0] inode_number;
  logic [15:0] block_number;

  modport source (output valid, new_inode, inode_number, block_number, input ready);
  modport sink   (input valid, new_inode, inode_number, block_number, output ready);
endinterface

interface bct_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic        mark_for_clear;
  logic [15:0] inode_to_clear;
  logic [15:0] used_count;
  logic [7:0]  dup_entries;

  modport source (output valid, verdict, mark_for_clear, inode_to_clear, used_count,
                  dup_entries, input ready);
  modport sink   (input valid, verdict, mark_for_clear, inode_to_clear, used_count,
                  dup_entries, output ready);
endinterface

interface bct_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bct_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/bct_busy_map.sv
module bct_busy_map (
  input  logic                      clk,
  input  logic                      rst,
  input  bct_pkg::map_req_t         req,
  output logic [15:0]               rd_data,
  output logic                      ready
);

  logic [15:0]               mem [bct_pkg::MAP_ROWS];
  logic [bct_pkg::ROW_W-1:0] clr_row;
  logic                      clearing;

  // sweep every row to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == bct_pkg::ROW_W'(bct_pkg::MAP_ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_row <= clr_row + bct_pkg::ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (req.wr) begin
      mem[req.row] <= req.wdata;
    end
    if (req.rd) begin
      rd_data <= mem[req.row];
    end
  end

  assign ready = !clearing;

endmodule

// File: hdl/block_claim_dup_tracker.sv
// steps: a bad block goes lookup, done; a fresh one lookup, test, done; a recorded duplicate
//   adds the table scan after test, and a new distinct block then moves the first repeat to
//   the end of the table and inserts itself; a dup limit or a full table ends it at test
// flow: one claim at a time, and a stalled result word holds off the next claim
// reset: synchronous; counters cleared, busy map swept a row a cycle, all 4096 rows, first
module block_claim_dup_tracker (
  input logic          clk,
  input logic          rst,
  bct_claim_if.sink    claim,
  bct_result_if.source result,
  bct_cfg_if.sink      cfg
);

  bct_pkg::state_t state, state_next;

  logic [15:0] total_blocks;
  logic [15:0] inode_blocks;
  logic [3:0]  max_bad;
  logic [3:0]  max_dup;

  logic [15:0] blk;
  logic [15:0] ino;
  logic [3:0]  bad_seen;
  logic [3:0]  dup_seen;
  logic [15:0] used_total;
  logic [bct_pkg::DUP_W-1:0] dup_fill;
  logic [bct_pkg::DUP_W-1:0] distinct_fill;
  logic [bct_pkg::DUP_W-1:0] scan_idx;
  logic        scan_pend;
  bct_pkg::verdict_t res_verdict;
  logic        res_mark;

  bct_pkg::map_req_t map_req;
  logic [15:0] map_q;
  logic        map_ready;

  logic [15:0] tab [bct_pkg::DUP_ENTRIES];
  logic [15:0] tab_q;
  logic        tab_we;
  logic [bct_pkg::IDX_W-1:0] tab_waddr;
  logic [bct_pkg::IDX_W-1:0] tab_raddr;
  logic [15:0] tab_wdata;

  logic        is_bad;
  logic [3:0]  bad_inc;
  logic [3:0]  dup_inc;
  logic        busy_bit;
  logic        table_full;
  logic        scan_issue;
  logic        scan_hit;
  logic        scan_miss;
  logic        out_free;
  logic        in_fire;

  bct_busy_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (map_q),
    .ready   (map_ready)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= 16'hffff;
      inode_blocks <= 16'h0000;
      max_bad      <= 4'd10;
      max_dup      <= 4'd10;
    end else if (cfg.valid) begin
      unique case (bct_pkg::cfg_reg_t'(cfg.index))
        bct_pkg::REG_TOTAL_BLOCKS: total_blocks <= cfg.data;
        bct_pkg::REG_INODE_BLOCKS: inode_blocks <= cfg.data;
        bct_pkg::REG_MAX_BAD:      max_bad      <= cfg.data[3:0];
        bct_pkg::REG_MAX_DUP:      max_dup      <= cfg.data[3:0];
      endcase
    end
  end

  // outside the data area, or past the end of the map
  assign is_bad = ({1'b0, blk} < ({1'b0, inode_blocks} + 17'd2))
               || (blk >= total_blocks)
               || ({1'b0, blk} >= 17'(bct_pkg::BLOCK_COUNT));

  assign bad_inc    = bct_pkg::sat_inc(bad_seen);
  assign dup_inc    = bct_pkg::sat_inc(dup_seen);
  assign busy_bit   = map_q[blk[3:0]];
  assign table_full = dup_fill >= bct_pkg::DUP_W'(bct_pkg::DUP_ENTRIES);

  // scan reads one entry a cycle and compares it the cycle after
  assign scan_issue = scan_idx < distinct_fill;
  assign scan_hit   = scan_pend && (tab_q == blk);
  assign scan_miss  = !scan_pend && !scan_issue;

  assign out_free = !result.valid || result.ready;
  assign in_fire  = claim.valid && claim.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      bct_pkg::ST_IDLE:    if (in_fire) state_next = bct_pkg::ST_LOOKUP;
      bct_pkg::ST_LOOKUP:  state_next = is_bad ? bct_pkg::ST_DONE : bct_pkg::ST_TEST;
      bct_pkg::ST_TEST: begin
        if (!busy_bit || dup_inc >= max_dup || table_full) begin
          state_next = bct_pkg::ST_DONE;
        end else begin
          state_next = bct_pkg::ST_SCAN;
        end
      end
      bct_pkg::ST_SCAN: begin
        priority if (scan_hit) begin
          state_next = bct_pkg::ST_DONE;
        end else if (scan_miss) begin
          state_next = bct_pkg::ST_MOVE_RD;
        end else begin
          state_next = bct_pkg::ST_SCAN;
        end
      end
      bct_pkg::ST_MOVE_RD: state_next = bct_pkg::ST_MOVE_WR;
      bct_pkg::ST_MOVE_WR: state_next = bct_pkg::ST_INSERT;
      bct_pkg::ST_INSERT:  state_next = bct_pkg::ST_DONE;
      bct_pkg::ST_DONE:    if (out_free) state_next = bct_pkg::ST_IDLE;
      default:             state_next = bct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    claim.ready   = 1'b0;
    map_req.rd    = 1'b0;
    map_req.wr    = 1'b0;
    map_req.row   = blk[bct_pkg::ROW_W+3:4];
    map_req.wdata = map_q | (16'h0001 << blk[3:0]);
    tab_we        = 1'b0;
    tab_waddr     = dup_fill[bct_pkg::IDX_W-1:0];
    tab_wdata     = blk;
    tab_raddr     = scan_idx[bct_pkg::IDX_W-1:0];
    unique case (state)
      bct_pkg::ST_IDLE:    claim.ready = map_ready;
      bct_pkg::ST_LOOKUP:  map_req.rd = !is_bad;
      bct_pkg::ST_TEST:    map_req.wr = !busy_bit;
      bct_pkg::ST_SCAN:    tab_we = scan_hit;
      bct_pkg::ST_MOVE_RD: tab_raddr = distinct_fill[bct_pkg::IDX_W-1:0];
      bct_pkg::ST_MOVE_WR: begin
        // first repeat goes to the end of the table
        tab_we    = 1'b1;
        tab_wdata = tab_q;
      end
      bct_pkg::ST_INSERT: begin
        tab_we    = 1'b1;
        tab_waddr = distinct_fill[bct_pkg::IDX_W-1:0];
      end
      bct_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab[tab_waddr] <= tab_wdata;
    end
    tab_q <= tab[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= bct_pkg::ST_IDLE;
      bad_seen      <= '0;
      dup_seen      <= '0;
      used_total    <= '0;
      dup_fill      <= '0;
      distinct_fill <= '0;
      result.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bct_pkg::ST_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        bct_pkg::ST_IDLE: begin
          if (in_fire) begin
            blk <= claim.block_number;
            ino <= claim.inode_number;
            if (claim.new_inode) begin
              bad_seen <= '0;
              dup_seen <= '0;
            end
          end
        end
        bct_pkg::ST_LOOKUP: begin
          if (is_bad) begin
            bad_seen    <= bad_inc;
            res_mark    <= 1'b1;
            res_verdict <= (bad_inc >= max_bad) ? bct_pkg::V_STOP_BAD : bct_pkg::V_BAD;
          end
        end
        bct_pkg::ST_TEST: begin
          scan_idx  <= '0;
          scan_pend <= 1'b0;
          if (!busy_bit) begin
            used_total  <= used_total + 16'd1;
            res_mark    <= 1'b0;
            res_verdict <= bct_pkg::V_CONTINUE;
          end else begin
            dup_seen <= dup_inc;
            res_mark <= 1'b1;
            priority if (dup_inc >= max_dup) begin
              res_verdict <= bct_pkg::V_STOP_DUP;
            end else if (table_full) begin
              res_verdict <= bct_pkg::V_STOP_FULL;
            end else begin
              res_verdict <= bct_pkg::V_DUP;
            end
          end
        end
        bct_pkg::ST_SCAN: begin
          scan_pend <= scan_issue;
          if (scan_issue) begin
            scan_idx <= scan_idx + bct_pkg::DUP_W'(1);
          end
          if (scan_hit) begin
            dup_fill <= dup_fill + bct_pkg::DUP_W'(1);
          end
        end
        bct_pkg::ST_MOVE_RD: ;
        bct_pkg::ST_MOVE_WR: ;
        bct_pkg::ST_INSERT: begin
          dup_fill      <= dup_fill + bct_pkg::DUP_W'(1);
          distinct_fill <= distinct_fill + bct_pkg::DUP_W'(1);
        end
        bct_pkg::ST_DONE: ;
        default: ;
      endcase
    end
  end

  // result word loads as the item leaves the done state
  always_ff @(posedge clk) begin
    if (state == bct_pkg::ST_DONE && out_free) begin
      result.verdict        <= res_verdict;
      result.mark_for_clear <= res_mark;
      result.inode_to_clear <= res_mark ? ino : 16'h0000;
      result.used_count     <= used_total;
      result.dup_entries    <= 8'(dup_fill);
    end
  end

endmodule

// File: hdl/bct_checker.sv
module bct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  verdict,
  input logic        mark_for_clear,
  input logic [15:0] inode_to_clear
);

  // one claim in flight: no second word taken straight after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("claim taken while previous claim still in progress");

  a_mark_matches_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mark_for_clear == (verdict != bct_pkg::V_CONTINUE)))
    else $error("mark_for_clear does not follow verdict");

  a_clear_ino_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mark_for_clear |-> inode_to_clear == 16'h0000)
    else $error("inode to clear set without mark_for_clear");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(inode_to_clear))
    else $error("stalled result word changed");

endmodule

bind block_claim_dup_tracker bct_checker u_bct_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (claim.valid),
  .in_ready       (claim.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .verdict        (result.verdict),
  .mark_for_clear (result.mark_for_clear),
  .inode_to_clear (result.inode_to_clear)
);
